// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files of the WSPR message encoder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define WSPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wspr assertion failed");

// Next-cycle implication, disabled while reset is low.
`define WSPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wspr assertion failed");

`endif

// ----- sv/wspr_pkg.sv -----
// Package of the WSPR message encoder: frame constants, sync vector,
// inter-module structs and character helper functions. No dependencies.
package wspr_pkg;

    localparam int NSYM    = 162;
    localparam int SYM_AW  = 8;
    localparam int CALL_W  = 28;
    localparam int GRID_W  = 22;
    localparam int WORD_W  = CALL_W + GRID_W;

    localparam logic [31:0] GEN_A = 32'hF2D05351;
    localparam logic [31:0] GEN_B = 32'hE4613C47;

    localparam logic [5:0] CODE_SPACE = 6'd36;
    localparam logic [5:0] CODE_BAD   = 6'd63;

    // Sync vector, symbol 0 leftmost.
    localparam logic [0:NSYM-1] SYNC = {
        32'b11000000_10001110_00100101_11100000,
        32'b00100101_00000010_11001101_00011010,
        32'b00011010_10101001_00101100_01101010,
        32'b00100000_10010011_10110011_01000111,
        32'b00000101_00110000_00011010_11000110,
        2'b00
    };

    typedef struct packed {
        logic done;
        logic error;
    } t_pack_status;

    typedef struct packed {
        logic              we;
        logic [SYM_AW-1:0] addr;
        logic              data;
    } t_ram_wr;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // 0-9 -> 0..9, A-Z -> 10..35, space -> 36, anything else -> CODE_BAD.
    function automatic logic [5:0] sym_code(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (is_digit(c)) begin
            t = c - 8'h30;
            return t[5:0];
        end
        if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'h41 + 8'd10;
            return t[5:0];
        end
        if (c == 8'h20) begin
            return CODE_SPACE;
        end
        return CODE_BAD;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] i);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[7-b] = i[b];
        end
        return r;
    endfunction

endpackage

// ----- sv/wspr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wspr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 162
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/wspr_packer.sv -----
// Message packer: checks the callsign, locator and power and builds the
// 50-bit source word with one shared multiply-accumulate unit. Uses wspr_pkg.
module wspr_packer import wspr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [7:0]        i_call [6],
    input  logic [7:0]        i_grid [4],
    input  logic [7:0]        i_power,
    output t_pack_status      o_status,
    output logic [WORD_W-1:0] o_word
);

    localparam logic [2:0] STEP_LAST_CALL = 3'd5;
    localparam logic [2:0] STEP_GRID      = 3'd6;
    localparam logic [2:0] STEP_PWR       = 3'd7;

    logic [7:0]        r_call [6];
    logic [7:0]        r_grid [4];
    logic [7:0]        r_power;
    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_step;
    logic [CALL_W-1:0] r_acc;
    logic [CALL_W-1:0] r_callv;

    logic [7:0]        tmp [6];
    logic [5:0]        present;
    logic              shift;
    logic [7:0]        cs [6];
    logic [5:0]        code [6];
    logic              call_ok;
    logic              grid_ok;
    logic [7:0]        f0, f1;
    logic [7:0]        m0;
    logic [7:0]        grid_add;
    logic [CALL_W-1:0] mul_a;
    logic [7:0]        mul_b;
    logic [7:0]        add_v;
    logic [CALL_W-1:0] n_acc;

    // Callsign alignment and character checks.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            tmp[i] = fold_case(r_call[i]);
        end
        present[0] = (r_call[0] != 8'd0);
        for (int i = 1; i < 6; i++) begin
            present[i] = present[i-1] && (r_call[i] != 8'd0);
        end
        shift = present[1] && is_digit(tmp[1]);
        cs[0] = shift ? 8'h20 : (present[0] ? tmp[0] : 8'h20);
        for (int i = 1; i < 6; i++) begin
            if (shift) begin
                cs[i] = present[i-1] ? tmp[i-1] : 8'h20;
            end else begin
                cs[i] = present[i] ? tmp[i] : 8'h20;
            end
        end
        for (int i = 0; i < 6; i++) begin
            code[i] = sym_code(cs[i]);
        end
        call_ok = (code[0] != CODE_BAD)
               && (code[1] != CODE_BAD) && (code[1] <= 6'd35)
               && (code[2] <= 6'd9);
        for (int i = 3; i < 6; i++) begin
            call_ok = call_ok && (code[i] != CODE_BAD) && (code[i] >= 6'd10);
        end
    end

    // Locator and power checks.
    always_comb begin
        f0 = fold_case(r_grid[0]);
        f1 = fold_case(r_grid[1]);
        grid_ok = (f0 >= 8'h41) && (f0 <= 8'h52) && (f1 >= 8'h41) && (f1 <= 8'h52)
               && is_digit(r_grid[2]) && is_digit(r_grid[3]) && (r_power <= 8'd60);
        m0       = 8'd179 - 8'(8'd10 * (f0 - 8'h41)) - (r_grid[2] - 8'h30);
        grid_add = 8'(8'd10 * (f1 - 8'h41)) + (r_grid[3] - 8'h30);
    end

    // Shared multiply-accumulate operand select.
    always_comb begin
        mul_a = r_acc;
        mul_b = 8'd0;
        add_v = 8'd0;
        case (r_step)
            3'd0: begin
                // Start from a clean accumulator.
                mul_a = '0;
                mul_b = 8'd0;
                add_v = {2'b00, code[0]};
            end
            3'd1: begin
                mul_b = 8'd36;
                add_v = {2'b00, code[1]};
            end
            3'd2: begin
                mul_b = 8'd10;
                add_v = {2'b00, code[2]};
            end
            3'd3, 3'd4, STEP_LAST_CALL: begin
                mul_b = 8'd27;
                add_v = {2'b00, code[r_step]} - 8'd10;
            end
            STEP_GRID: begin
                mul_a = CALL_W'(m0);
                mul_b = 8'd180;
                add_v = grid_add;
            end
            STEP_PWR: begin
                mul_b = 8'd128;
                add_v = r_power + 8'd64;
            end
            default: begin
                mul_b = 8'd0;
            end
        endcase
        n_acc = CALL_W'(mul_a * mul_b + CALL_W'(add_v));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == STEP_PWR) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_call  <= i_call;
            r_grid  <= i_grid;
            r_power <= i_power;
        end
        if (r_busy) begin
            r_acc <= n_acc;
            if (r_step == STEP_LAST_CALL) begin
                r_callv <= n_acc;
            end
        end
    end

    assign o_status.done  = r_done;
    assign o_status.error = !(call_ok && grid_ok);
    assign o_word         = {r_callv, r_acc[GRID_W-1:0]};

endmodule

// ----- sv/wspr_conv.sv -----
// Convolutional encoder and interleaver: sweeps 256 bit-reversed slots and
// writes each code bit to its frame position in the symbol RAM. Uses wspr_pkg.
module wspr_conv import wspr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_word,
    output logic              o_done,
    output t_ram_wr           o_wr
);

    logic              r_busy;
    logic              r_done;
    logic [7:0]        r_slot;
    logic              r_odd;
    logic [31:0]       r_sr;
    logic [WORD_W-1:0] r_word;

    logic [7:0]  dest;
    logic        hit;
    logic [31:0] sr_shift;

    always_comb begin
        dest     = rev8(r_slot);
        hit      = r_busy && (dest < 8'(NSYM));
        sr_shift = {r_sr[30:0], r_word[WORD_W-1]};
        o_wr.we   = hit;
        o_wr.addr = dest;
        o_wr.data = r_odd ? ^(r_sr & GEN_B) : ^(sr_shift & GEN_A);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_slot == 8'hFF) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Advance the shift register on the first bit of each pair; zeros
    // follow the source word as the tail.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_slot <= 8'd0;
            r_odd  <= 1'b0;
            r_sr   <= 32'd0;
            r_word <= i_word;
        end else if (r_busy) begin
            r_slot <= r_slot + 8'd1;
            if (hit) begin
                r_odd <= !r_odd;
                if (!r_odd) begin
                    r_sr   <= sr_shift;
                    r_word <= {r_word[WORD_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_done = r_done;

endmodule

// ----- sv/wspr_message_encoder.sv -----
// Top level of the WSPR message encoder: sequencer, symbol RAM readout and
// result registers. Uses wspr_pkg, assert_macros.svh, wspr_packer, wspr_conv, wspr_ram.
//
// One transaction on start (taken when busy is low) carries a whole message:
// six callsign bytes, four locator bytes and the power. A valid message gives
// 41 results, one per strobe, four symbols each (sync plus twice the data bit),
// group_index counting 0..40; the last one carries symbols 160 and 161 with
// sym_c and sym_d zero and last_group set. An invalid message gives a single
// result with error_flag and last_group set and all symbols zero. The receiver
// cannot stall: each result is on the ports for exactly one cycle and must be
// taken then. A valid message occupies the block for 8 multiply-accumulate
// steps that pack the source word, a sweep over the 256 bit-reversed
// interleave slots that runs the K=32 encoder one code bit per in-frame slot,
// and a readout of the 162 symbols from the one-bit symbol RAM. busy stays
// high until the final result is registered.
`include "assert_macros.svh"

module wspr_message_encoder import wspr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_call_char_0,
    input  logic [7:0] i_call_char_1,
    input  logic [7:0] i_call_char_2,
    input  logic [7:0] i_call_char_3,
    input  logic [7:0] i_call_char_4,
    input  logic [7:0] i_call_char_5,
    input  logic [7:0] i_grid_char_0,
    input  logic [7:0] i_grid_char_1,
    input  logic [7:0] i_grid_char_2,
    input  logic [7:0] i_grid_char_3,
    input  logic [7:0] i_power_dbm,
    output logic       o_strobe,
    output logic [1:0] o_sym_a,
    output logic [1:0] o_sym_b,
    output logic [1:0] o_sym_c,
    output logic [1:0] o_sym_d,
    output logic [5:0] o_group_index,
    output logic       o_last_group,
    output logic       o_error_flag
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PACK = 3'd1;
    localparam logic [2:0] ST_CONV = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_LAST = 3'd4;

    localparam logic [SYM_AW-1:0] LAST_SYM = SYM_AW'(NSYM - 1);

    logic [2:0]        r_state;
    logic [SYM_AW-1:0] r_rd_addr;
    logic              r_rd_valid;
    logic [SYM_AW-1:0] r_rd_idx;
    logic [1:0]        r_buf [3];
    logic              r_strobe;
    logic [1:0]        r_sym [4];
    logic [5:0]        r_group;
    logic              r_last;
    logic              r_err;

    logic              accept;
    logic [7:0]        call_bytes [6];
    logic [7:0]        grid_bytes [4];
    t_pack_status      pack_st;
    logic [WORD_W-1:0] word;
    logic              conv_start;
    logic              conv_done;
    t_ram_wr           wr;
    logic              rdata;
    logic [1:0]        cur_sym;
    logic [1:0]        cur_k;
    logic              emit;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    assign call_bytes = '{i_call_char_0, i_call_char_1, i_call_char_2,
                          i_call_char_3, i_call_char_4, i_call_char_5};
    assign grid_bytes = '{i_grid_char_0, i_grid_char_1, i_grid_char_2, i_grid_char_3};

    wspr_packer u_packer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_call   (call_bytes),
        .i_grid   (grid_bytes),
        .i_power  (i_power_dbm),
        .o_status (pack_st),
        .o_word   (word)
    );

    assign conv_start = (r_state == ST_PACK) && pack_st.done && !pack_st.error;

    wspr_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_word  (word),
        .o_done  (conv_done),
        .o_wr    (wr)
    );

    wspr_ram #(
        .WIDTH (1),
        .DEPTH (NSYM)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (r_rd_addr),
        .o_rdata (rdata)
    );

    // Symbol read back this cycle and whether it closes a group.
    always_comb begin
        cur_sym = {rdata, SYNC[r_rd_idx]};
        cur_k   = r_rd_idx[1:0];
        emit    = r_rd_valid && ((cur_k == 2'd3) || (r_rd_idx == LAST_SYM));
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_rd_valid <= 1'b0;
            r_strobe   <= emit;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_PACK;
                    end
                end
                ST_PACK: begin
                    if (pack_st.done) begin
                        if (pack_st.error) begin
                            r_strobe <= 1'b1;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_state <= ST_CONV;
                        end
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_rd_valid <= 1'b1;
                    if (r_rd_addr == LAST_SYM) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    // Final symbol is captured this cycle.
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Readout address and group assembly.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CONV) begin
            r_rd_addr <= '0;
        end else if (r_state == ST_READ) begin
            r_rd_addr <= r_rd_addr + SYM_AW'(1);
        end
        r_rd_idx <= r_rd_addr;

        if (r_rd_valid && cur_k != 2'd3) begin
            r_buf[cur_k] <= cur_sym;
        end

        if (r_state == ST_PACK && pack_st.done && pack_st.error) begin
            r_sym   <= '{2'd0, 2'd0, 2'd0, 2'd0};
            r_group <= 6'd0;
            r_last  <= 1'b1;
            r_err   <= 1'b1;
        end else if (emit) begin
            r_group <= r_rd_idx[SYM_AW-1:2];
            r_err   <= 1'b0;
            if (r_rd_idx == LAST_SYM) begin
                // Short group: two symbols, rest zero.
                r_sym  <= '{r_buf[0], cur_sym, 2'd0, 2'd0};
                r_last <= 1'b1;
            end else begin
                r_sym  <= '{r_buf[0], r_buf[1], r_buf[2], cur_sym};
                r_last <= 1'b0;
            end
        end
    end

    assign o_strobe      = r_strobe;
    assign o_sym_a       = r_sym[0];
    assign o_sym_b       = r_sym[1];
    assign o_sym_c       = r_sym[2];
    assign o_sym_d       = r_sym[3];
    assign o_group_index = r_group;
    assign o_last_group  = r_last;
    assign o_error_flag  = r_err;

    `WSPR_ASSERT_IMP(a_err_is_last, i_clk, i_rst_n, o_strobe && o_error_flag, o_last_group && o_sym_a == 2'd0)
    `WSPR_ASSERT_IMP(a_last_at_40, i_clk, i_rst_n, o_strobe && !o_error_flag, o_last_group == (o_group_index == 6'd40))
    `WSPR_ASSERT_IMP(a_group_pace, i_clk, i_rst_n, o_strobe && !o_error_flag && o_group_index < 6'd39, ##4 o_strobe)
    `WSPR_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, busy)

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for wspr_message_encoder: drives whole messages through the
// start/busy command port and checks every strobed symbol group against a local model.
// Depends only on the encoder RTL (wspr_pkg and its submodules).

module tb_top;

    // Frame constants of the channel code, kept local to the predictor.
    localparam int          FRAME_SYMS  = 162;
    localparam int          FRAME_GROUPS = 41;
    localparam int          SOURCE_BITS = 50;
    localparam int          CODED_STEPS = 81;
    localparam logic [31:0] POLY_A      = 32'hF2D05351;
    localparam logic [31:0] POLY_B      = 32'hE4613C47;
    localparam int          MAX_POWER   = 60;

    // Sync vector, symbol 0 leftmost.
    localparam logic [0:FRAME_SYMS-1] FRAME_SYNC = {
        32'b11000000_10001110_00100101_11100000,
        32'b00100101_00000010_11001101_00011010,
        32'b00011010_10101001_00101100_01101010,
        32'b00100000_10010011_10110011_01000111,
        32'b00000101_00110000_00011010_11000110,
        2'b00
    };

    // Worst quiet stretch of a correct run is roughly 8 packing steps plus the
    // 256-slot interleave sweep plus a sender gap; allow several times that.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct packed {
        logic [0:5][7:0] call;
        logic [0:3][7:0] grid;
        logic [7:0]      power;
    } t_message;

    typedef struct packed {
        logic [0:3][1:0] sym;
        logic [5:0]      idx;
        logic            last;
        logic            err;
    } t_group;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_message cur_msg;
    logic     o_strobe;
    logic [1:0] o_sym_a, o_sym_b, o_sym_c, o_sym_d;
    logic [5:0] o_group_index;
    logic       o_last_group;
    logic       o_error_flag;

    t_group pending_groups[$];
    int     idle_pct;
    int     mismatch_count;
    int     groups_seen;
    int     messages_taken;
    int     rejected_count;
    int     stall_cycles;

    wspr_message_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_call_char_0 (cur_msg.call[0]),
        .i_call_char_1 (cur_msg.call[1]),
        .i_call_char_2 (cur_msg.call[2]),
        .i_call_char_3 (cur_msg.call[3]),
        .i_call_char_4 (cur_msg.call[4]),
        .i_call_char_5 (cur_msg.call[5]),
        .i_grid_char_0 (cur_msg.grid[0]),
        .i_grid_char_1 (cur_msg.grid[1]),
        .i_grid_char_2 (cur_msg.grid[2]),
        .i_grid_char_3 (cur_msg.grid[3]),
        .i_power_dbm   (cur_msg.power),
        .o_strobe      (o_strobe),
        .o_sym_a       (o_sym_a),
        .o_sym_b       (o_sym_b),
        .o_sym_c       (o_sym_c),
        .o_sym_d       (o_sym_d),
        .o_group_index (o_group_index),
        .o_last_group  (o_last_group),
        .o_error_flag  (o_error_flag)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= "a" && c <= "z") begin
            return c - 8'd32;
        end
        return c;
    endfunction

    // Digits rank 0..9, letters 10..35, space 36; anything else is -1.
    function automatic int char_rank(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return c - "0";
        end
        if (c >= "A" && c <= "Z") begin
            return c - "A" + 10;
        end
        if (c == " ") begin
            return 36;
        end
        return -1;
    endfunction

    // Work out the symbol groups that one message must produce and queue them.
    function automatic void predict_message(input t_message m);
        logic [7:0]  raw [6];
        logic [7:0]  slot [6];
        int          rank [6];
        int          len;
        int          p;
        bit          ok;
        logic [7:0]  f0, f1, s0, s1;
        logic [31:0] call_val, grid_val;
        logic [49:0] word;
        logic [31:0] sr;
        logic [0:FRAME_SYMS-1] coded, placed;
        logic [7:0]  fwd, rev;
        t_group      grp;

        // Collect the callsign up to its terminator, folding case.
        len = 0;
        while (len < 6 && m.call[len] != 8'h00) begin
            raw[len] = to_upper(m.call[len]);
            len++;
        end
        for (int i = 0; i < 6; i++) begin
            slot[i] = " ";
        end
        // A digit in second place means a one-letter prefix: shift right by one.
        if (len >= 2 && raw[1] >= "0" && raw[1] <= "9") begin
            for (int i = 0; i < len && i < 5; i++) begin
                slot[i + 1] = raw[i];
            end
        end else begin
            for (int i = 0; i < len; i++) begin
                slot[i] = raw[i];
            end
        end
        for (int i = 0; i < 6; i++) begin
            rank[i] = char_rank(slot[i]);
        end
        ok = rank[0] >= 0 && rank[1] >= 0 && rank[1] <= 35 && rank[2] >= 0 && rank[2] <= 9;
        for (int i = 3; i < 6; i++) begin
            if (rank[i] < 10) begin
                ok = 0;
            end
        end

        f0 = to_upper(m.grid[0]);
        f1 = to_upper(m.grid[1]);
        s0 = m.grid[2];
        s1 = m.grid[3];
        if (f0 < "A" || f0 > "R" || f1 < "A" || f1 > "R") begin
            ok = 0;
        end
        if (s0 < "0" || s0 > "9" || s1 < "0" || s1 > "9") begin
            ok = 0;
        end
        if (m.power > MAX_POWER) begin
            ok = 0;
        end

        if (!ok) begin
            grp      = '0;
            grp.last = 1'b1;
            grp.err  = 1'b1;
            pending_groups.push_back(grp);
            rejected_count++;
            return;
        end

        call_val = rank[0];
        call_val = call_val * 36 + rank[1];
        call_val = call_val * 10 + rank[2];
        for (int i = 3; i < 6; i++) begin
            call_val = call_val * 27 + (rank[i] - 10);
        end
        grid_val = (179 - 10 * (f0 - "A") - (s0 - "0")) * 180;
        grid_val = grid_val + 10 * (f1 - "A") + (s1 - "0");
        grid_val = grid_val * 128 + m.power + 64;
        word = {call_val[27:0], grid_val[21:0]};

        // Rate-1/2 convolutional code over the source bits plus the zero tail.
        sr = '0;
        for (int i = 0; i < CODED_STEPS; i++) begin
            sr = {sr[30:0], (i < SOURCE_BITS) ? word[SOURCE_BITS - 1 - i] : 1'b0};
            coded[2 * i]     = ^(sr & POLY_A);
            coded[2 * i + 1] = ^(sr & POLY_B);
        end

        // Bit-reversal interleave: skip slots that land past the frame.
        placed = '0;
        p = 0;
        for (int i = 0; i < 256 && p < FRAME_SYMS; i++) begin
            fwd = 8'(i);
            for (int b = 0; b < 8; b++) begin
                rev[7 - b] = fwd[b];
            end
            if (rev < FRAME_SYMS) begin
                placed[rev] = coded[p];
                p++;
            end
        end

        // Symbol = sync + 2 * data, four to a group; the short last group pads with zero.
        for (int g = 0; g < FRAME_GROUPS; g++) begin
            grp = '0;
            for (int k = 0; k < 4; k++) begin
                if (g * 4 + k < FRAME_SYMS) begin
                    grp.sym[k] = {placed[g * 4 + k], FRAME_SYNC[g * 4 + k]};
                end
            end
            grp.idx  = 6'(g);
            grp.last = (g == FRAME_GROUPS - 1);
            pending_groups.push_back(grp);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Pop before push so a final group and a new transaction on one edge stay ordered.
    always @(posedge i_clk) begin : result_monitor
        t_group want;
        if (i_rst_n) begin
            if (o_strobe) begin
                groups_seen++;
                if (pending_groups.size() == 0) begin
                    $display("%0t: unexpected symbol group, expected none, got index %0d",
                             $time, o_group_index);
                    mismatch_count++;
                end else begin
                    want = pending_groups.pop_front();
                    check_field("sym_a", want.sym[0], o_sym_a);
                    check_field("sym_b", want.sym[1], o_sym_b);
                    check_field("sym_c", want.sym[2], o_sym_c);
                    check_field("sym_d", want.sym[3], o_sym_d);
                    check_field("group_index", want.idx, o_group_index);
                    check_field("last_group", want.last, o_last_group);
                    check_field("error_flag", want.err, o_error_flag);
                end
            end
            if (start && !busy) begin
                messages_taken++;
                predict_message(cur_msg);
            end
            // Reset the stall count on any transaction or result.
            if (o_strobe || (start && !busy)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d groups outstanding",
                         $time, pending_groups.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Hold the message on the ports and raise start on non-idle cycles until taken.
    task automatic send_message(input t_message m);
        bit taken;
        taken = 0;
        @(negedge i_clk);
        cur_msg <= m;
        while (!taken) begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge i_clk);
            taken = start && !busy;
            if (!taken) begin
                @(negedge i_clk);
            end
        end
    endtask

    function automatic t_message make_msg(input string call, input string grid, input int pwr);
        t_message m;
        for (int i = 0; i < 6; i++) begin
            m.call[i] = (i < call.len()) ? call[i] : 8'h00;
        end
        for (int i = 0; i < 4; i++) begin
            m.grid[i] = (i < grid.len()) ? grid[i] : 8'h00;
        end
        m.power = 8'(pwr);
        return m;
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'("A" + $urandom_range(25));
        if ($urandom_range(1)) begin
            c = c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return $urandom_range(1) ? rand_letter() : rand_digit();
    endfunction

    // Well-formed message with random content, either layout of the callsign.
    function automatic t_message valid_message();
        t_message m;
        int       len;
        logic [7:0] c;
        m.call = '0;
        if ($urandom_range(1)) begin
            // Prefix layout; a sixth character is dropped, so let it be any byte.
            len = $urandom_range(6, 2);
            m.call[0] = rand_alnum();
            m.call[1] = rand_digit();
            for (int i = 2; i < len; i++) begin
                c = 8'($urandom_range(255, 1));
                m.call[i] = (i == 5) ? c : rand_letter();
            end
        end else begin
            len = $urandom_range(6, 3);
            m.call[0] = ($urandom_range(7) == 0) ? " " : rand_alnum();
            m.call[1] = rand_letter();
            m.call[2] = rand_digit();
            for (int i = 3; i < len; i++) begin
                m.call[i] = ($urandom_range(3) == 0) ? " " : rand_letter();
            end
        end
        // Bytes past the terminator must be ignored.
        for (int i = len + 1; i < 6; i++) begin
            m.call[i] = 8'($urandom_range(255));
        end
        for (int i = 0; i < 2; i++) begin
            c = 8'("A" + $urandom_range(17));
            m.grid[i] = $urandom_range(1) ? c + 8'd32 : c;
        end
        m.grid[2] = rand_digit();
        m.grid[3] = rand_digit();
        m.power = 8'($urandom_range(MAX_POWER));
        return m;
    endfunction

    // Corrupt one field of a well-formed message.
    function automatic t_message broken_message();
        t_message m;
        int       pick;
        m = valid_message();
        pick = $urandom_range(10);
        if (pick < 6) begin
            m.call[pick] = 8'($urandom_range(255));
        end else if (pick < 10) begin
            m.grid[pick - 6] = 8'($urandom_range(255));
        end else begin
            m.power = 8'($urandom_range(255, MAX_POWER + 1));
        end
        return m;
    endfunction

    function automatic t_message noise_message();
        t_message m;
        for (int i = 0; i < 6; i++) begin
            m.call[i] = 8'($urandom_range(255));
        end
        for (int i = 0; i < 4; i++) begin
            m.grid[i] = 8'($urandom_range(255));
        end
        m.power = 8'($urandom_range(255));
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, both callsign layouts, case folding and each reject reason.
    task automatic test_directed();
        t_message m;
        send_message(make_msg("AB1CDE", "AA00", 0));
        send_message(make_msg("ZZ9ZZZ", "RR99", MAX_POWER));
        send_message(make_msg("ab1cde", "rr99", 37));
        send_message(make_msg("W1XYZ", "JO21", 30));
        send_message(make_msg("A1BCDE", "FN42", 10));   // prefix layout drops the sixth
        send_message(make_msg("Q9", "AA99", 5));
        send_message(make_msg("00", "RA09", 60));
        send_message(make_msg("9Z9", "aR90", 1));
        send_message(make_msg(" A1XY", "CM87", 23));    // leading space in first place
        m = make_msg("AB1", "KP20", 40);                // junk after the terminator
        m.call[4] = 8'hFF;
        m.call[5] = 8'h80;
        send_message(m);
        send_message(make_msg("", "AA00", 0));          // empty callsign
        send_message(make_msg("A", "AA00", 0));         // single character
        send_message(make_msg("ABC", "AA00", 0));       // third place not a digit
        send_message(make_msg("AB1C2", "AA00", 0));     // digit in the suffix
        send_message(make_msg("ab1{", "AA00", 0));      // just past z is not folded
        m = make_msg("AB1XYZ", "AA00", 0);              // non-ASCII byte in the callsign
        m.call[0] = 8'hC1;
        send_message(m);
        send_message(make_msg("AB1XYZ", "SA00", 0));    // field letter past R
        send_message(make_msg("AB1XYZ", "As00", 0));
        send_message(make_msg("AB1XYZ", "AA:0", 0));    // square not a digit
        send_message(make_msg("AB1XYZ", "AA0/", 0));
        send_message(make_msg("AB1XYZ", "AA0", 0));     // zero byte in the locator
        send_message(make_msg("AB1XYZ", "AA00", MAX_POWER + 1));
        send_message(make_msg("AB1XYZ", "AA00", 255));
    endtask

    // Mostly well-formed messages, the rest corrupted or pure noise.
    task automatic test_random(input int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                send_message(valid_message());
            end else if (sel < 90) begin
                send_message(broken_message());
            end else begin
                send_message(noise_message());
            end
        end
    endtask

    // Hold start low until every queued group has come out.
    task automatic test_drain_pause();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_groups.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        cur_msg        = '0;
        idle_pct       = 14;
        mismatch_count = 0;
        groups_seen    = 0;
        messages_taken = 0;
        rejected_count = 0;
        stall_cycles   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(135);
        test_drain_pause();
        idle_pct = 86;
        test_random(135);
        test_drain_pause();
        idle_pct = 0;
        test_random(135);
        test_drain_pause();

        // Let any stray strobe show up before closing.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Encoded %0d messages (%0d rejected), checked %0d symbol groups.",
                 messages_taken, rejected_count, groups_seen);
        $display("Sender idle at 14, 86 and 0 percent, with full drains between phases.");
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/wspr_pkg.sv
sv/wspr_ram.sv
sv/wspr_packer.sv
sv/wspr_conv.sv
sv/wspr_message_encoder.sv
tb/sv/tb_top.sv
